// File: rtl/core/dgfs_pkg.sv
// dgfs_pkg: shared constants, codes and types for the diagonal Gaussian fit/score block.
// No dependencies; compiled first.
package dgfs_pkg;

	localparam int KIND_W     = 2;
	localparam int FEAT_W     = 24;
	localparam int STATUS_W   = 3;
	localparam int SCORE_W    = 48;
	localparam int FCOUNT_W   = 5;
	localparam int IV_W       = 32;
	localparam int WIDE_W     = 64;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 48;
	localparam int FRAC_SHIFT = 40;
	localparam int TERM_SHIFT = 25;

	localparam int MUL_STEPS = 32;
	localparam int DIV_STEPS = 64;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam logic [KIND_W-1:0] KIND_TRAIN    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FINISH   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SCORE    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

	localparam logic [STATUS_W-1:0] ST_SCORE_READY = 3'd0;
	localparam logic [STATUS_W-1:0] ST_TRAIN_DONE  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_SAMPLES  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_MISMATCH    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_TRAINED = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_FEATURE_COUNT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 1'd1;

	localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
	localparam logic [IV_W-1:0]    IV_MAX    = '1;

	typedef enum logic {
		ARITH_MUL,
		ARITH_DIV
	} arith_op_t;

	typedef struct packed {
		logic      start;
		arith_op_t op;
	} arith_req_t;

endpackage

// File: rtl/core/dgfs_sample_if.sv
// dgfs_sample_if: valid/ready channel carrying one input element.
// Depends on dgfs_pkg.
interface dgfs_sample_if;
	logic                              valid;
	logic                              ready;
	logic [dgfs_pkg::KIND_W-1:0]       kind;
	logic signed [dgfs_pkg::FEAT_W-1:0] feature_value;
	logic                              last_element;

	modport source(output valid, kind, feature_value, last_element, input ready);
	modport sink(input valid, kind, feature_value, last_element, output ready);
endinterface

// File: rtl/core/dgfs_result_if.sv
// dgfs_result_if: valid/ready channel carrying one result.
// Depends on dgfs_pkg.
interface dgfs_result_if;
	logic                          valid;
	logic                          ready;
	logic [dgfs_pkg::STATUS_W-1:0] status;
	logic [dgfs_pkg::SCORE_W-1:0]  score;
	logic                          is_cell;

	modport source(output valid, status, score, is_cell, input ready);
	modport sink(input valid, status, score, is_cell, output ready);
endinterface

// File: rtl/core/dgfs_ram.sv
// dgfs_ram: single write port, single read port synchronous RAM, registered read data.
// No package dependency.
module dgfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/dgfs_arith.sv
// dgfs_arith: shared serial unit, shift-add multiply (low 64 bits) or restoring divide.
// Depends on dgfs_pkg.
module dgfs_arith (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dgfs_pkg::arith_req_t          req,
	input  logic [dgfs_pkg::WIDE_W-1:0]   op_a,
	input  logic [dgfs_pkg::WIDE_W-1:0]   op_b,
	output logic                          done,
	output logic [dgfs_pkg::WIDE_W-1:0]   res
);

	logic                          busy_q;
	logic                          done_q;
	dgfs_pkg::arith_op_t           op_q;
	logic [dgfs_pkg::STEP_W-1:0]   cnt_q;
	logic [dgfs_pkg::WIDE_W-1:0]   a_q;
	logic [dgfs_pkg::WIDE_W-1:0]   b_q;
	logic [dgfs_pkg::WIDE_W-1:0]   acc_q;
	logic [dgfs_pkg::WIDE_W:0]     rem_q;
	logic [dgfs_pkg::WIDE_W:0]     rem_sh;
	logic                          fits;

	assign rem_sh = {rem_q[dgfs_pkg::WIDE_W-1:0], a_q[dgfs_pkg::WIDE_W-1]};
	assign fits   = rem_sh >= {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= dgfs_pkg::ARITH_MUL;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= (req.op == dgfs_pkg::ARITH_MUL) ?
					dgfs_pkg::STEP_W'(dgfs_pkg::MUL_STEPS - 1) :
					dgfs_pkg::STEP_W'(dgfs_pkg::DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= op_a;
			b_q   <= op_b;
			acc_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			if (op_q == dgfs_pkg::ARITH_MUL) begin
				if (b_q[0]) begin
					acc_q <= acc_q + a_q;
				end
				a_q <= a_q << 1;
				b_q <= b_q >> 1;
			end else if (fits) begin
				rem_q <= rem_sh - {1'b0, b_q};
				a_q   <= {a_q[dgfs_pkg::WIDE_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				a_q   <= {a_q[dgfs_pkg::WIDE_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign res  = (op_q == dgfs_pkg::ARITH_DIV) ? a_q : acc_q;

endmodule

// File: rtl/core/diagonal_gaussian_fit_and_score_top.sv
// Diagonal Gaussian fit and score: per-feature statistics RAM, model RAM, serial mul/div unit.
// Training: IDLE, EXEC. Scoring: model RAM read, then states EXEC, PA, PB, TERM, ACC, SC_END.
// Finish per feature: divide, three multiplies, divide (serial unit: 64-step div, 32-step mul).
// One item in flight; a result waits in an output register while the next item is taken.
// Async reset clears control state and the statistics valid bits; no clearing pass.
module diagonal_gaussian_fit_and_score_top #(
	parameter int MAX_FEATURES      = 16,
	parameter int SAMPLE_COUNT_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dgfs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dgfs_pkg::CFG_DATA_W-1:0]   cfg_data,
	dgfs_sample_if.sink                       sample,
	dgfs_result_if.source                     result
);

	localparam int ADDR_W   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int DEPTH_P2 = 2 ** ADDR_W;
	localparam int POS_W    = $clog2(MAX_FEATURES + 2);
	localparam int FJ_W     = $clog2(MAX_FEATURES + 1);
	localparam int CNT_W    = ((POS_W > dgfs_pkg::FCOUNT_W) ? POS_W : dgfs_pkg::FCOUNT_W) + 1;
	localparam int SUM_W    = dgfs_pkg::FEAT_W + SAMPLE_COUNT_BITS;
	localparam int STAT_W   = SUM_W + dgfs_pkg::WIDE_W;
	localparam int MODEL_W  = dgfs_pkg::FEAT_W + dgfs_pkg::IV_W;
	localparam int SQ_W     = 2 * dgfs_pkg::FEAT_W;
	localparam int D_W      = dgfs_pkg::FEAT_W + 1;
	localparam int PP_W     = dgfs_pkg::WIDE_W;
	localparam int TS_W     = PP_W + 16;
	localparam int TERM_W   = TS_W - dgfs_pkg::TERM_SHIFT;
	localparam int ACC_W    = TERM_W + 1;
	localparam logic [SAMPLE_COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_FEATURES + 1);
	localparam logic [FJ_W-1:0]  FJ_LAST   = FJ_W'(MAX_FEATURES - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_PA, S_PB, S_TERM, S_ACC, S_SC_END,
		S_F_RD, S_F_LD, S_F_CALC, S_F_DEV, S_F_WR, S_F_END, S_EMIT
	} state_t;

	typedef enum logic [2:0] {
		CALC_MEAN, CALC_P1, CALC_P2, CALC_P3, CALC_IV
	} calc_t;

	state_t state_q;
	calc_t  calc_q;

	logic [dgfs_pkg::FCOUNT_W-1:0] fcount_q;
	logic [dgfs_pkg::SCORE_W-1:0]  thr_q;

	logic [POS_W-1:0]             pos_q;
	logic [SAMPLE_COUNT_BITS-1:0] ncount_q;
	logic [dgfs_pkg::SCORE_W-1:0] acc_q;
	logic                         ready_q;
	logic [DEPTH_P2-1:0]          stat_vld_q;
	logic [ADDR_W-1:0]            rd_addr_q;

	logic [dgfs_pkg::KIND_W-1:0]        kind_q;
	logic signed [dgfs_pkg::FEAT_W-1:0] x_q;
	logic                               last_q;
	logic [POS_W-1:0]                   idx_q;
	logic [SQ_W-1:0]                    xsq_q;

	logic [SQ_W-1:0]            d2_s1;
	logic [dgfs_pkg::IV_W-1:0]  iv_s1;
	logic [PP_W-1:0]            pa_s2;
	logic [PP_W-1:0]            pb_s3;
	logic [TERM_W-1:0]          term_s4;

	logic [FJ_W-1:0]                    fj_q;
	logic                               issued_q;
	logic signed [SUM_W-1:0]            sum_q;
	logic [dgfs_pkg::WIDE_W-1:0]        sq_q;
	logic [dgfs_pkg::FEAT_W-1:0]        mean_q;
	logic [dgfs_pkg::FEAT_W-1:0]        mu_mag_q;
	logic [dgfs_pkg::WIDE_W-1:0]        p1_q;
	logic [dgfs_pkg::WIDE_W-1:0]        p2_q;
	logic [dgfs_pkg::WIDE_W-1:0]        p3_q;
	logic [dgfs_pkg::WIDE_W-1:0]        dev_q;
	logic [dgfs_pkg::IV_W-1:0]          iv_q;

	logic [dgfs_pkg::STATUS_W-1:0] pend_status_q;
	logic [dgfs_pkg::SCORE_W-1:0]  pend_score_q;
	logic                          pend_cell_q;
	logic                          res_valid_q;
	logic [dgfs_pkg::STATUS_W-1:0] res_status_q;
	logic [dgfs_pkg::SCORE_W-1:0]  res_score_q;
	logic                          res_cell_q;

	logic [CNT_W-1:0]   cnt_used;
	logic [POS_W-1:0]   seen;
	logic               idx_in;
	logic               mismatch;
	logic               full;
	logic               fj_in;
	logic               rd_vld;
	logic signed [SUM_W-1:0]      rd_sum;
	logic [dgfs_pkg::WIDE_W-1:0]  rd_sq;
	logic signed [SUM_W-1:0]      new_sum;
	logic [dgfs_pkg::WIDE_W-1:0]  new_sq;
	logic signed [SQ_W-1:0]       xsq_full;
	logic signed [dgfs_pkg::FEAT_W-1:0] mean_rd;
	logic [dgfs_pkg::IV_W-1:0]    iv_rd;
	logic signed [D_W-1:0]        diff;
	logic signed [D_W-1:0]        ndiff;
	logic [dgfs_pkg::FEAT_W-1:0]  dabs;
	logic [TS_W-1:0]              term_sum;
	logic [ACC_W-1:0]             nacc;
	logic [SUM_W-1:0]             sum_mag;
	logic [dgfs_pkg::WIDE_W-1:0]  prod;
	logic [dgfs_pkg::WIDE_W-1:0]  dev;
	logic [dgfs_pkg::WIDE_W-1:0]  n_wide;

	logic                 stat_we;
	logic [ADDR_W-1:0]    stat_raddr;
	logic [STAT_W-1:0]    stat_rdata;
	logic                 model_we;
	logic [MODEL_W-1:0]   model_rdata;

	dgfs_pkg::arith_req_t        arith_req;
	logic [dgfs_pkg::WIDE_W-1:0] arith_a;
	logic [dgfs_pkg::WIDE_W-1:0] arith_b;
	logic                        arith_done;
	logic [dgfs_pkg::WIDE_W-1:0] arith_res;

	always_comb begin
		cnt_used = CNT_W'(fcount_q);
		if (fcount_q == '0) begin
			cnt_used = CNT_W'(1);
		end else if (CNT_W'(fcount_q) > CNT_W'(MAX_FEATURES)) begin
			cnt_used = CNT_W'(MAX_FEATURES);
		end
	end

	assign seen     = (idx_q < POS_LIMIT) ? idx_q + POS_W'(1) : POS_LIMIT;
	assign idx_in   = CNT_W'(idx_q) < cnt_used;
	assign mismatch = CNT_W'(seen) != cnt_used;
	assign full     = ncount_q == COUNT_MAX;
	assign fj_in    = CNT_W'(fj_q) < cnt_used;

	assign rd_vld  = stat_vld_q[rd_addr_q];
	assign rd_sum  = rd_vld ? signed'(stat_rdata[STAT_W-1:dgfs_pkg::WIDE_W]) : '0;
	assign rd_sq   = rd_vld ? stat_rdata[dgfs_pkg::WIDE_W-1:0] : '0;
	assign new_sum = rd_sum + SUM_W'(x_q);
	assign new_sq  = rd_sq + dgfs_pkg::WIDE_W'(xsq_q);
	assign xsq_full = sample.feature_value * sample.feature_value;

	assign mean_rd = signed'(model_rdata[MODEL_W-1:dgfs_pkg::IV_W]);
	assign iv_rd   = model_rdata[dgfs_pkg::IV_W-1:0];
	assign diff    = D_W'(x_q) - D_W'(mean_rd);
	assign ndiff   = -diff;
	assign dabs    = diff[D_W-1] ? ndiff[dgfs_pkg::FEAT_W-1:0] : diff[dgfs_pkg::FEAT_W-1:0];

	assign term_sum = {pa_s2, 16'b0} + {16'b0, pb_s3};
	assign nacc     = ACC_W'(acc_q) + ACC_W'(term_s4);

	assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign prod    = (sum_q[SUM_W-1] ^ mean_q[dgfs_pkg::FEAT_W-1]) ? -p1_q : p1_q;
	assign dev     = sq_q - (prod << 1) + p3_q;
	assign n_wide  = dgfs_pkg::WIDE_W'(ncount_q);

	always_comb begin
		arith_req.start = (state_q == S_F_CALC) && !issued_q;
		arith_req.op    = dgfs_pkg::ARITH_MUL;
		arith_a         = '0;
		arith_b         = '0;
		case (calc_q)
			CALC_MEAN: begin
				arith_req.op = dgfs_pkg::ARITH_DIV;
				arith_a      = dgfs_pkg::WIDE_W'(sum_mag) + (n_wide >> 1);
				arith_b      = n_wide;
			end
			CALC_P1: begin
				arith_a = dgfs_pkg::WIDE_W'(sum_mag);
				arith_b = dgfs_pkg::WIDE_W'(mu_mag_q);
			end
			CALC_P2: begin
				arith_a = dgfs_pkg::WIDE_W'(mu_mag_q);
				arith_b = dgfs_pkg::WIDE_W'(mu_mag_q);
			end
			CALC_P3: begin
				arith_a = p2_q;
				arith_b = n_wide;
			end
			default: begin
				arith_req.op = dgfs_pkg::ARITH_DIV;
				arith_a      = n_wide << dgfs_pkg::FRAC_SHIFT;
				arith_b      = dev_q;
			end
		endcase
	end

	assign stat_we    = (state_q == S_EXEC) && (kind_q == dgfs_pkg::KIND_TRAIN) && !full && idx_in;
	assign stat_raddr = (state_q == S_IDLE) ? pos_q[ADDR_W-1:0] : fj_q[ADDR_W-1:0];
	assign model_we   = state_q == S_F_WR;

	dgfs_ram #(
		.WIDTH(STAT_W),
		.DEPTH(MAX_FEATURES)
	) u_stat_ram (
		.clk  (clk),
		.we   (stat_we),
		.waddr(idx_q[ADDR_W-1:0]),
		.wdata({new_sum, new_sq}),
		.raddr(stat_raddr),
		.rdata(stat_rdata)
	);

	dgfs_ram #(
		.WIDTH(MODEL_W),
		.DEPTH(MAX_FEATURES)
	) u_model_ram (
		.clk  (clk),
		.we   (model_we),
		.waddr(fj_q[ADDR_W-1:0]),
		.wdata({mean_q, iv_q}),
		.raddr(pos_q[ADDR_W-1:0]),
		.rdata(model_rdata)
	);

	dgfs_arith u_arith (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (arith_req),
		.op_a  (arith_a),
		.op_b  (arith_b),
		.done  (arith_done),
		.res   (arith_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcount_q <= dgfs_pkg::FCOUNT_W'(16);
			thr_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dgfs_pkg::REG_FEATURE_COUNT:   fcount_q <= cfg_data[dgfs_pkg::FCOUNT_W-1:0];
				dgfs_pkg::REG_SCORE_THRESHOLD: thr_q <= cfg_data[dgfs_pkg::SCORE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_q <= stat_raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			calc_q        <= CALC_MEAN;
			pos_q         <= '0;
			ncount_q      <= '0;
			acc_q         <= '0;
			ready_q       <= 1'b0;
			stat_vld_q    <= '0;
			issued_q      <= 1'b0;
			fj_q          <= '0;
			kind_q        <= '0;
			x_q           <= '0;
			last_q        <= 1'b0;
			idx_q         <= '0;
			xsq_q         <= '0;
			d2_s1         <= '0;
			iv_s1         <= '0;
			pa_s2         <= '0;
			pb_s3         <= '0;
			term_s4       <= '0;
			sum_q         <= '0;
			sq_q          <= '0;
			mean_q        <= '0;
			mu_mag_q      <= '0;
			p1_q          <= '0;
			p2_q          <= '0;
			p3_q          <= '0;
			dev_q         <= '0;
			iv_q          <= '0;
			pend_status_q <= dgfs_pkg::ST_SCORE_READY;
			pend_score_q  <= '0;
			pend_cell_q   <= 1'b0;
			res_valid_q   <= 1'b0;
			res_status_q  <= dgfs_pkg::ST_SCORE_READY;
			res_score_q   <= '0;
			res_cell_q    <= 1'b0;
		end else begin
			if (res_valid_q && result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (sample.valid) begin
						kind_q <= sample.kind;
						x_q    <= sample.feature_value;
						last_q <= sample.last_element;
						idx_q  <= pos_q;
						xsq_q  <= SQ_W'(xsq_full);
						if (sample.kind != dgfs_pkg::KIND_RESERVED) begin
							state_q <= S_EXEC;
						end
					end
				end
				S_EXEC: begin
					pend_score_q <= '0;
					pend_cell_q  <= 1'b0;
					if (kind_q == dgfs_pkg::KIND_FINISH) begin
						pos_q <= '0;
						acc_q <= '0;
						if (ncount_q == '0) begin
							pend_status_q <= dgfs_pkg::ST_NO_SAMPLES;
							state_q       <= S_EMIT;
						end else begin
							fj_q    <= '0;
							state_q <= S_F_RD;
						end
					end else if (kind_q == dgfs_pkg::KIND_TRAIN) begin
						pos_q <= last_q ? '0 : seen;
						if (stat_we) begin
							stat_vld_q[idx_q[ADDR_W-1:0]] <= 1'b1;
						end
						state_q <= S_IDLE;
						if (last_q) begin
							if (!full) begin
								ncount_q <= ncount_q + 1'b1;
							end
							if (mismatch) begin
								pend_status_q <= dgfs_pkg::ST_MISMATCH;
								state_q       <= S_EMIT;
							end
						end
					end else begin
						pos_q <= last_q ? '0 : seen;
						if (!ready_q) begin
							acc_q   <= '0;
							state_q <= S_IDLE;
							if (last_q) begin
								pend_status_q <= dgfs_pkg::ST_NOT_TRAINED;
								state_q       <= S_EMIT;
							end
						end else if (idx_in) begin
							d2_s1   <= SQ_W'(dabs) * SQ_W'(dabs);
							iv_s1   <= iv_rd;
							state_q <= S_PA;
						end else begin
							state_q <= S_SC_END;
						end
					end
				end
				S_PA: begin
					pa_s2   <= PP_W'(d2_s1) * PP_W'(iv_s1[31:16]);
					state_q <= S_PB;
				end
				S_PB: begin
					pb_s3   <= PP_W'(d2_s1) * PP_W'(iv_s1[15:0]);
					state_q <= S_TERM;
				end
				S_TERM: begin
					term_s4 <= term_sum[TS_W-1:dgfs_pkg::TERM_SHIFT];
					state_q <= S_ACC;
				end
				S_ACC: begin
					acc_q   <= (|nacc[ACC_W-1:dgfs_pkg::SCORE_W]) ? dgfs_pkg::SCORE_MAX :
						nacc[dgfs_pkg::SCORE_W-1:0];
					state_q <= S_SC_END;
				end
				S_SC_END: begin
					state_q <= S_IDLE;
					if (last_q) begin
						acc_q   <= '0;
						state_q <= S_EMIT;
						if (mismatch) begin
							pend_status_q <= dgfs_pkg::ST_MISMATCH;
							pend_score_q  <= '0;
							pend_cell_q   <= 1'b0;
						end else begin
							pend_status_q <= dgfs_pkg::ST_SCORE_READY;
							pend_score_q  <= acc_q;
							pend_cell_q   <= acc_q < thr_q;
						end
					end
				end
				S_F_RD: begin
					state_q <= S_F_LD;
				end
				S_F_LD: begin
					if (fj_in) begin
						sum_q    <= rd_sum;
						sq_q     <= rd_sq;
						calc_q   <= CALC_MEAN;
						issued_q <= 1'b0;
						state_q  <= S_F_CALC;
					end else begin
						mean_q  <= '0;
						iv_q    <= '0;
						state_q <= S_F_WR;
					end
				end
				S_F_CALC: begin
					if (arith_req.start) begin
						issued_q <= 1'b1;
					end
					if (arith_done) begin
						issued_q <= 1'b0;
						case (calc_q)
							CALC_MEAN: begin
								mu_mag_q <= arith_res[dgfs_pkg::FEAT_W-1:0];
								mean_q   <= sum_q[SUM_W-1] ?
									(~arith_res[dgfs_pkg::FEAT_W-1:0] + 1'b1) :
									arith_res[dgfs_pkg::FEAT_W-1:0];
								calc_q   <= CALC_P1;
							end
							CALC_P1: begin
								p1_q   <= arith_res;
								calc_q <= CALC_P2;
							end
							CALC_P2: begin
								p2_q   <= arith_res;
								calc_q <= CALC_P3;
							end
							CALC_P3: begin
								p3_q    <= arith_res;
								state_q <= S_F_DEV;
							end
							default: begin
								iv_q    <= (|arith_res[dgfs_pkg::WIDE_W-1:dgfs_pkg::IV_W]) ?
									dgfs_pkg::IV_MAX : arith_res[dgfs_pkg::IV_W-1:0];
								state_q <= S_F_WR;
							end
						endcase
					end
				end
				S_F_DEV: begin
					if (dev == '0) begin
						iv_q    <= dgfs_pkg::IV_MAX;
						state_q <= S_F_WR;
					end else begin
						dev_q    <= dev;
						calc_q   <= CALC_IV;
						issued_q <= 1'b0;
						state_q  <= S_F_CALC;
					end
				end
				S_F_WR: begin
					fj_q <= fj_q + 1'b1;
					if (fj_q == FJ_LAST) begin
						state_q <= S_F_END;
					end else begin
						state_q <= S_F_RD;
					end
				end
				S_F_END: begin
					stat_vld_q    <= '0;
					ncount_q      <= '0;
					ready_q       <= 1'b1;
					pend_status_q <= dgfs_pkg::ST_TRAIN_DONE;
					pend_score_q  <= '0;
					pend_cell_q   <= 1'b0;
					state_q       <= S_EMIT;
				end
				S_EMIT: begin
					if (!res_valid_q || result.ready) begin
						res_valid_q  <= 1'b1;
						res_status_q <= pend_status_q;
						res_score_q  <= pend_score_q;
						res_cell_q   <= pend_cell_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign sample.ready   = state_q == S_IDLE;
	assign result.valid   = res_valid_q;
	assign result.status  = res_status_q;
	assign result.score   = res_score_q;
	assign result.is_cell = res_cell_q;

endmodule

// File: rtl/core/dgfs_checker.sv
// dgfs_checker: port-level assertions for the fit/score top level, bound below.
// Depends on dgfs_pkg and diagonal_gaussian_fit_and_score_top.
module dgfs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_valid,
	input logic                          s_ready,
	input logic                          r_valid,
	input logic                          r_ready,
	input logic [dgfs_pkg::STATUS_W-1:0] r_status,
	input logic [dgfs_pkg::SCORE_W-1:0]  r_score,
	input logic                          r_cell
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_score) && $stable(r_status))
		else $error("result changed while stalled");

	a_non_score_zero: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && (r_status != dgfs_pkg::ST_SCORE_READY) |-> (r_score == '0) && !r_cell)
		else $error("non-score result carries score or is_cell");

	a_handshake_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(s_ready) && !$isunknown(r_valid))
		else $error("handshake signal unknown");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(r_valid) |-> $past(!s_ready))
		else $error("result appeared without an element in work");

endmodule

bind diagonal_gaussian_fit_and_score_top dgfs_checker u_dgfs_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_valid (sample.valid),
	.s_ready (sample.ready),
	.r_valid (result.valid),
	.r_ready (result.ready),
	.r_status(result.status),
	.r_score (result.score),
	.r_cell  (result.is_cell)
);

// File: sim/diagonal_gaussian_fit_and_score_top_tb.sv
// Testbench for diagonal_gaussian_fit_and_score_top: directed and random training/scoring runs
// checked against a built-in predictor. Depends on dgfs_pkg, dgfs_sample_if, dgfs_result_if.
module diagonal_gaussian_fit_and_score_top_tb;
	import dgfs_pkg::*;

	localparam int NFEAT      = 16;
	localparam int COUNT_FULL = 65535;
	localparam int SETTLE     = 60;
	localparam int LIMIT      = 4000000;
	localparam int RUN_VECS   = 40;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [SCORE_W-1:0]  score;
		logic                is_cell;
	} gauss_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	dgfs_sample_if smp();
	dgfs_result_if res();

	diagonal_gaussian_fit_and_score_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample(smp),
		.result(res)
	);

	always #2 clk = ~clk;

	initial begin
		smp.valid = 1'b0;
		smp.kind = KIND_TRAIN;
		smp.feature_value = '0;
		smp.last_element = 1'b0;
		res.ready = 1'b0;
	end

	// predictor state
	logic [FCOUNT_W-1:0] fcount_reg = 5'd16;
	logic [SCORE_W-1:0]  threshold_reg = '0;
	longint              sum_x [NFEAT];
	bit [63:0]           sum_sq [NFEAT];
	int                  mean_q [NFEAT];
	bit [31:0]           inv_var [NFEAT];
	bit [63:0]           samples;
	int unsigned         position;
	bit [SCORE_W-1:0]    score_acc;
	bit                  trained;

	gauss_result_t expected_results [$];
	int errors = 0;
	int cycles = 0;
	int send_idle = 0;
	int recv_idle = 0;
	int scored_items = 0;

	initial begin
		for (int j = 0; j < NFEAT; j++) begin
			sum_x[j] = 0; sum_sq[j] = 0; mean_q[j] = 0; inv_var[j] = 0;
		end
		samples = 0; position = 0; score_acc = 0; trained = 0;
	end

	function automatic int unsigned used_count();
		int unsigned c;
		c = fcount_reg;
		if (c < 1) c = 1;
		if (c > NFEAT) c = NFEAT;
		return c;
	endfunction

	function automatic void fit_model(int unsigned cnt);
		bit [63:0] n, mag, q, mu, dev;
		longint m;
		n = samples;
		for (int j = 0; j < NFEAT; j++) begin
			if (j < cnt) begin
				mag = sum_x[j] < 0 ? 64'(-sum_x[j]) : 64'(sum_x[j]);
				q = (mag + n / 2) / n;
				m = sum_x[j] < 0 ? -longint'(q) : longint'(q);
				mean_q[j] = int'(m);
				mu = 64'(m);
				dev = sum_sq[j] - 64'd2 * mu * 64'(sum_x[j]) + n * mu * mu;
				if (dev == 0) begin
					inv_var[j] = IV_MAX;
				end else begin
					q = (n << FRAC_SHIFT) / dev;
					inv_var[j] = q > 64'hFFFF_FFFF ? IV_MAX : q[31:0];
				end
			end else begin
				mean_q[j] = 0;
				inv_var[j] = 0;
			end
			sum_x[j] = 0;
			sum_sq[j] = 0;
		end
		samples = 0;
		trained = 1;
	endfunction

	function automatic bit gauss_step(input logic [KIND_W-1:0] kind,
			input logic signed [FEAT_W-1:0] fv, input logic last, output gauss_result_t r);
		longint x, d;
		int unsigned cnt, idx, seen;
		bit full;
		bit [63:0] ad2;
		bit [127:0] prod;
		bit [63:0] t, s;
		r.status = ST_SCORE_READY;
		r.score = '0;
		r.is_cell = 1'b0;
		x = fv;
		cnt = used_count();
		idx = position;
		if (kind == KIND_RESERVED) return 0;
		if (kind == KIND_FINISH) begin
			position = 0;
			score_acc = 0;
			if (samples == 0) begin
				r.status = ST_NO_SAMPLES;
				return 1;
			end
			fit_model(cnt);
			r.status = ST_TRAIN_DONE;
			return 1;
		end
		seen = idx < NFEAT + 1 ? idx + 1 : NFEAT + 1;
		position = last ? 0 : seen;
		if (kind == KIND_TRAIN) begin
			full = samples >= COUNT_FULL;
			if (!full && idx < cnt) begin
				sum_x[idx] += x;
				sum_sq[idx] += 64'(x * x);
			end
			if (!last) return 0;
			if (!full) samples++;
			if (seen != cnt) begin
				r.status = ST_MISMATCH;
				return 1;
			end
			return 0;
		end
		if (!trained) begin
			score_acc = 0;
			if (!last) return 0;
			r.status = ST_NOT_TRAINED;
			return 1;
		end
		if (idx < cnt) begin
			d = x - longint'(mean_q[idx]);
			if (d < 0) d = -d;
			ad2 = 64'(d) * 64'(d);
			prod = {64'd0, ad2} * {96'd0, inv_var[idx]};
			t = 64'(prod >> TERM_SHIFT);
			score_acc = (t >= 64'(SCORE_MAX) - 64'(score_acc)) ? SCORE_MAX
				: score_acc + t[SCORE_W-1:0];
		end
		if (!last) return 0;
		s = score_acc;
		score_acc = 0;
		if (seen != cnt) begin
			r.status = ST_MISMATCH;
			return 1;
		end
		r.score = s[SCORE_W-1:0];
		r.is_cell = s < 64'(threshold_reg);
		return 1;
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(negedge clk)
		if (arst_n) res.ready <= ($urandom_range(0, 99) >= recv_idle);

	always @(posedge clk) begin
		gauss_result_t want;
		if (arst_n && res.valid && res.ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result, status", res.status, 0);
			end else begin
				want = expected_results.pop_front();
				if (res.status !== want.status)
					report_mismatch("status", res.status, want.status);
				if (res.score !== want.score)
					report_mismatch("score", res.score, want.score);
				if (res.is_cell !== want.is_cell)
					report_mismatch("is_cell", res.is_cell, want.is_cell);
			end
		end
	end

	task automatic send_item(logic [KIND_W-1:0] kind, logic [FEAT_W-1:0] fv, logic last);
		gauss_result_t r;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle) begin
			smp.valid <= 1'b0;
			@(negedge clk);
		end
		smp.valid <= 1'b1;
		smp.kind <= kind;
		smp.feature_value <= fv;
		smp.last_element <= last;
		do @(posedge clk); while (!smp.ready);
		if (gauss_step(kind, fv, last, r)) expected_results.push_back(r);
		if (kind != KIND_RESERVED) scored_items++;
	endtask

	// drop valid, drain results, then let any result-free item finish
	task automatic settle();
		@(negedge clk);
		smp.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FEATURE_COUNT) fcount_reg = val[FCOUNT_W-1:0];
		else threshold_reg = val[SCORE_W-1:0];
	endtask

	function automatic logic [FEAT_W-1:0] pick_feature(logic [FEAT_W-1:0] center, int sl);
		if ($urandom_range(0, 19) == 0) return FEAT_W'($urandom);
		return center + FEAT_W'($urandom_range(0, 2 << sl)) - FEAT_W'(1 << sl);
	endfunction

	task automatic send_vector(logic [KIND_W-1:0] kind, int len,
			logic [FEAT_W-1:0] center, int sl);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 29) == 0) send_item(KIND_RESERVED, FEAT_W'($urandom), 1'($urandom));
			send_item(kind, pick_feature(center, sl), i == len - 1);
		end
	endtask

	task automatic test_directed();
		send_item(KIND_SCORE, 24'h000123, 1'b0);
		send_item(KIND_SCORE, 24'hFFF000, 1'b1);
		send_item(KIND_FINISH, 24'h0, 1'b1);
		send_item(KIND_RESERVED, 24'hFFFFFF, 1'b1);
		settle();
		write_reg(REG_FEATURE_COUNT, 48'd2);
		write_reg(REG_SCORE_THRESHOLD, SCORE_MAX);
		send_item(KIND_TRAIN, 24'h7FFFFF, 1'b0);
		send_item(KIND_TRAIN, 24'h000005, 1'b1);
		send_item(KIND_TRAIN, 24'h800000, 1'b0);
		send_item(KIND_TRAIN, 24'h000005, 1'b1);
		send_item(KIND_TRAIN, 24'h000000, 1'b0);
		send_item(KIND_TRAIN, 24'h000005, 1'b1);
		send_item(KIND_FINISH, 24'h0, 1'b0);
		send_item(KIND_SCORE, 24'h000000, 1'b0);
		send_item(KIND_SCORE, 24'h000005, 1'b1);
		send_item(KIND_SCORE, 24'h7FFFFF, 1'b0);
		send_item(KIND_SCORE, 24'h800000, 1'b1);
		send_item(KIND_SCORE, 24'h000100, 1'b1);
		for (int i = 0; i < 3; i++) send_item(KIND_SCORE, 24'h000100, i == 2);
		send_item(KIND_TRAIN, 24'h001000, 1'b1);
		for (int i = 0; i < 3; i++) send_item(KIND_TRAIN, 24'hFFF000, i == 2);
		send_item(KIND_FINISH, 24'h0, 1'b1);
		settle();
		write_reg(REG_SCORE_THRESHOLD, 48'd0);
		send_item(KIND_SCORE, 24'h000200, 1'b0);
		send_item(KIND_SCORE, 24'h000300, 1'b1);
	endtask

	task automatic test_training_run();
		settle();
		write_reg(REG_FEATURE_COUNT, 48'd1);
		for (int i = 0; i < RUN_VECS; i++)
			send_item(KIND_TRAIN, FEAT_W'($urandom_range(0, 4095)), 1'b1);
		send_item(KIND_TRAIN, 24'h000010, 1'b0);
		send_item(KIND_TRAIN, 24'h000010, 1'b1);
		send_item(KIND_FINISH, 24'h0, 1'b1);
		send_item(KIND_SCORE, 24'h000800, 1'b1);
	endtask

	task automatic random_round();
		int cnt, len, sl;
		logic [FEAT_W-1:0] center;
		logic [63:0] thr;
		settle();
		case ($urandom_range(0, 5))
			0: write_reg(REG_FEATURE_COUNT, 48'($urandom_range(0, 31)));
			1: write_reg(REG_FEATURE_COUNT, $urandom_range(0, 1) ? 48'd16 : 48'd1);
			2: ;
			default: write_reg(REG_FEATURE_COUNT, 48'($urandom_range(1, 6)));
		endcase
		case ($urandom_range(0, 4))
			0: thr = $urandom_range(0, 1) ? 64'(SCORE_MAX) : 64'd0;
			1: thr = {$urandom, $urandom};
			default: thr = {$urandom, $urandom} >> $urandom_range(16, 63);
		endcase
		write_reg(REG_SCORE_THRESHOLD, thr[CFG_DATA_W-1:0]);
		cnt = used_count();
		center = FEAT_W'($urandom);
		sl = $urandom_range(0, 22);
		if ($urandom_range(0, 9) != 0) begin
			repeat ($urandom_range(0, 5)) begin
				len = $urandom_range(0, 9) == 0 ? $urandom_range(1, 18) : cnt;
				send_vector(KIND_TRAIN, len, center, sl);
			end
			send_item(KIND_FINISH, FEAT_W'($urandom), 1'($urandom));
		end
		repeat ($urandom_range(1, 8)) begin
			len = $urandom_range(0, 9) == 0 ? $urandom_range(1, 18) : cnt;
			send_vector(KIND_SCORE, len, center, $urandom_range(0, 1) ? sl : sl + 1);
		end
	endtask

	task automatic test_random(int sidle, int ridle, int items);
		int target;
		send_idle = sidle;
		recv_idle = ridle;
		target = scored_items + items;
		while (scored_items < target) random_round();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		recv_idle = 30;
		test_directed();
		test_random(25, 62, 360);
		test_random(62, 25, 360);
		test_random(0, 0, 360);
		send_idle = 0;
		test_training_run();
		settle();
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
